/* sv/tmg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the torus mesh generator.
// No dependencies.
package tmg_pkg;

    localparam int MAX_SIDES    = 256;
    localparam int MAX_RINGS    = 256;
    localparam int CORDIC_STEPS = 16;

    localparam int COUNT_W      = 9;
    localparam int SIDE_W       = 8;
    localparam int RAD_W        = 16;
    localparam int ANGLE_W      = 32;
    localparam int REM_W        = COUNT_W + 1;
    localparam int DIV_STEP_N   = 8;
    localparam int DIV_LAT      = ANGLE_W / DIV_STEP_N;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int MATH_LAT     = 3;
    localparam int QUAD_CORNERS = 6;
    localparam int IDX_W        = 17;
    localparam int POS_W        = 18;
    localparam int NRM_W        = 16;
    localparam int CORNER_W     = 3;

    localparam logic [1:0] REG_OUTER = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_SIDES = 2'd2;
    localparam logic [1:0] REG_RINGS = 2'd3;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_QUAD   = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic                bad;
        logic [CORNER_W-1:0] corner;
        logic [COUNT_W-1:0]  ring;
        logic [SIDE_W-1:0]   side;
    } t_sband;

    typedef struct packed {
        logic [RAD_W-1:0] outer;
        logic [RAD_W-1:0] inner;
    } t_radii;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ANGLE_W-1:0] q;
        logic [COUNT_W-1:0] cnt;
    } t_div;

    function automatic t_div div_steps(input t_div d);
        t_div             r;
        logic [REM_W-1:0] t;
        r = d;
        for (int k = 0; k < DIV_STEP_N; k++) begin
            t = {r.rem[REM_W-2:0], 1'b0};
            if (t >= {1'b0, r.cnt}) begin
                r.rem = t - {1'b0, r.cnt};
                r.q   = {r.q[ANGLE_W-2:0], 1'b1};
            end else begin
                r.rem = t;
                r.q   = {r.q[ANGLE_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic signed [32:0] atan_turn(input int i);
        case (i)
            0:  return 33'sd536870912;
            1:  return 33'sd316933406;
            2:  return 33'sd167458907;
            3:  return 33'sd85004756;
            4:  return 33'sd42667331;
            5:  return 33'sd21354465;
            6:  return 33'sd10680862;
            7:  return 33'sd5340245;
            8:  return 33'sd2670163;
            9:  return 33'sd1335087;
            10: return 33'sd667544;
            11: return 33'sd333772;
            12: return 33'sd166886;
            13: return 33'sd83443;
            14: return 33'sd41722;
            15: return 33'sd20861;
            16: return 33'sd10430;
            17: return 33'sd5215;
            18: return 33'sd2608;
            19: return 33'sd1304;
            20: return 33'sd652;
            21: return 33'sd326;
            22: return 33'sd163;
            23: return 33'sd81;
            default: return 33'sd0;
        endcase
    endfunction

endpackage

/* sv/tmg_angle_div.sv */
`timescale 1ns / 1ps
// Pipelined long divider: binary angle floor(idx * 2^32 / count) for idx < count, and zero for a nonzero count <= idx.
// Depends on tmg_pkg.
module tmg_angle_div (
    input  logic                         i_clk,
    input  logic [tmg_pkg::COUNT_W-1:0]  i_idx,
    input  logic [tmg_pkg::COUNT_W-1:0]  i_count,
    output logic [tmg_pkg::ANGLE_W-1:0]  o_angle
);
    import tmg_pkg::*;

    t_div r_st [DIV_LAT];
    t_div w_in;

    always_comb begin
        w_in.rem = (i_idx >= i_count) ? '0 : {1'b0, i_idx};
        w_in.q   = '0;
        w_in.cnt = i_count;
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= div_steps(w_in);
    end

    for (genvar s = 1; s < DIV_LAT; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_st[s] <= div_steps(r_st[s-1]);
        end
    end

    assign o_angle = r_st[DIV_LAT-1].q;

endmodule

/* sv/tmg_cordic.sv */
`timescale 1ns / 1ps
// Pipelined rotation CORDIC, one step per stage, with quadrant fold to Q1.14.
// Depends on tmg_pkg.
module tmg_cordic (
    input  logic                               i_clk,
    input  logic [tmg_pkg::ANGLE_W-1:0]        i_angle,
    output logic signed [tmg_pkg::NRM_W-1:0]   o_cos,
    output logic signed [tmg_pkg::NRM_W-1:0]   o_sin
);
    import tmg_pkg::*;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } t_cord;

    t_cord r_st [CORDIC_STEPS+1];

    function automatic logic signed [NRM_W-1:0] round_q14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) begin
            return 16'sd16384;
        end else if (t < -34'sd16384) begin
            return -16'sd16384;
        end
        return t[NRM_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r_st[0].x    <= 34'sd652032874;
        r_st[0].y    <= '0;
        r_st[0].z    <= $signed({3'b000, i_angle[ANGLE_W-3:0]});
        r_st[0].quad <= i_angle[ANGLE_W-1:ANGLE_W-2];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            r_st[i+1].quad <= r_st[i].quad;
            if (r_st[i].z >= 0) begin
                r_st[i+1].x <= r_st[i].x - (r_st[i].y >>> i);
                r_st[i+1].y <= r_st[i].y + (r_st[i].x >>> i);
                r_st[i+1].z <= r_st[i].z - atan_turn(i);
            end else begin
                r_st[i+1].x <= r_st[i].x + (r_st[i].y >>> i);
                r_st[i+1].y <= r_st[i].y - (r_st[i].x >>> i);
                r_st[i+1].z <= r_st[i].z + atan_turn(i);
            end
        end
    end

    logic signed [NRM_W-1:0] w_x;
    logic signed [NRM_W-1:0] w_y;

    assign w_x = round_q14(r_st[CORDIC_STEPS].x);
    assign w_y = round_q14(r_st[CORDIC_STEPS].y);

    always_ff @(posedge i_clk) begin
        case (r_st[CORDIC_STEPS].quad)
            2'd0: begin
                o_cos <= w_x;
                o_sin <= w_y;
            end
            2'd1: begin
                o_cos <= -w_y;
                o_sin <= w_x;
            end
            2'd2: begin
                o_cos <= -w_x;
                o_sin <= -w_y;
            end
            default: begin
                o_cos <= w_y;
                o_sin <= -w_x;
            end
        endcase
    end

endmodule

/* sv/tmg_vertex_math.sv */
`timescale 1ns / 1ps
// Three-stage position and normal arithmetic from sines and cosines.
// Depends on tmg_pkg.
module tmg_vertex_math (
    input  logic                               i_clk,
    input  tmg_pkg::t_radii                    i_radii,
    input  logic signed [tmg_pkg::NRM_W-1:0]   i_cu,
    input  logic signed [tmg_pkg::NRM_W-1:0]   i_su,
    input  logic signed [tmg_pkg::NRM_W-1:0]   i_cv,
    input  logic signed [tmg_pkg::NRM_W-1:0]   i_sv,
    output logic signed [tmg_pkg::POS_W-1:0]   o_px,
    output logic signed [tmg_pkg::POS_W-1:0]   o_py,
    output logic signed [tmg_pkg::POS_W-1:0]   o_pz,
    output logic signed [tmg_pkg::NRM_W-1:0]   o_nx,
    output logic signed [tmg_pkg::NRM_W-1:0]   o_ny,
    output logic signed [tmg_pkg::NRM_W-1:0]   o_nz
);
    import tmg_pkg::*;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [50:0] v);
        if (v > 51'sd131071) begin
            return 18'sd131071;
        end else if (v < -51'sd131072) begin
            return -18'sd131072;
        end
        return v[POS_W-1:0];
    endfunction

    logic signed [RAD_W:0]   w_rin;
    logic signed [32:0]      w_rcv;
    assign w_rin = $signed({1'b0, i_radii.inner});
    assign w_rcv = w_rin * i_cv;

    logic signed [34:0]      r_sum;
    logic signed [32:0]      r_pzp;
    logic signed [31:0]      r_nxp;
    logic signed [31:0]      r_nyp;
    logic signed [NRM_W-1:0] r_cu1;
    logic signed [NRM_W-1:0] r_su1;
    logic signed [NRM_W-1:0] r_sv1;

    always_ff @(posedge i_clk) begin
        r_sum <= $signed({5'b0, i_radii.outer, 14'b0}) + 35'(w_rcv);
        r_pzp <= w_rin * i_sv;
        r_nxp <= i_cv * i_cu;
        r_nyp <= i_cv * i_su;
        r_cu1 <= i_cu;
        r_su1 <= i_su;
        r_sv1 <= i_sv;
    end

    logic signed [31:0] w_nx;
    logic signed [31:0] w_ny;
    logic signed [32:0] w_pz;
    assign w_nx = (r_nxp + 32'sd8192) >>> 14;
    assign w_ny = (r_nyp + 32'sd8192) >>> 14;
    assign w_pz = (r_pzp + 33'sd8192) >>> 14;

    logic signed [50:0]      r_pxp;
    logic signed [50:0]      r_pyp;
    logic signed [POS_W-1:0] r_pz;
    logic signed [NRM_W-1:0] r_nx;
    logic signed [NRM_W-1:0] r_ny;
    logic signed [NRM_W-1:0] r_nz;

    always_ff @(posedge i_clk) begin
        r_pxp <= r_sum * r_cu1;
        r_pyp <= r_sum * r_su1;
        r_pz  <= sat_pos(51'(w_pz));
        if (r_sum == 0) begin
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= '0;
        end else if (r_sum < 0) begin
            r_nx <= -w_nx[NRM_W-1:0];
            r_ny <= -w_ny[NRM_W-1:0];
            r_nz <= -r_sv1;
        end else begin
            r_nx <= w_nx[NRM_W-1:0];
            r_ny <= w_ny[NRM_W-1:0];
            r_nz <= r_sv1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_px <= sat_pos((r_pxp + (51'sd1 <<< 27)) >>> 28);
        o_py <= sat_pos((r_pyp + (51'sd1 <<< 27)) >>> 28);
        o_pz <= r_pz;
        o_nx <= r_nx;
        o_ny <= r_ny;
        o_nz <= r_nz;
    end

endmodule

/* sv/torus_mesh_generator_unit.sv */
`timescale 1ns / 1ps
// Torus mesh generator top: APB registers, quad expansion, pipelines.
// From accept, a request passes the entry register, the angle dividers, the CORDICs and the vertex math.
// Throughput: one vertex request per cycle while busy is low; a valid quad request holds busy
// while the rest of its six corners enter the pipeline, one per cycle.
// Reset (synchronous, active low) restores the registers and drops all beats in flight.
// The receiver cannot stall; each result shows for one cycle on o_result_valid.
module torus_mesh_generator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_kind,
    input  logic [tmg_pkg::COUNT_W-1:0]         i_ring_index,
    input  logic [tmg_pkg::SIDE_W-1:0]          i_side_index,
    output logic                                o_result_valid,
    output logic signed [tmg_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [tmg_pkg::POS_W-1:0]    o_pos_y,
    output logic signed [tmg_pkg::POS_W-1:0]    o_pos_z,
    output logic signed [tmg_pkg::NRM_W-1:0]    o_normal_x,
    output logic signed [tmg_pkg::NRM_W-1:0]    o_normal_y,
    output logic signed [tmg_pkg::NRM_W-1:0]    o_normal_z,
    output logic [tmg_pkg::IDX_W-1:0]           o_vertex_index,
    output logic                                o_last,
    output logic                                o_bad_request
);
    import tmg_pkg::*;

    localparam int SB_LEN = DIV_LAT + CORDIC_LAT + MATH_LAT;

    logic [RAD_W-1:0]   r_outer;
    logic [RAD_W-1:0]   r_inner;
    logic [COUNT_W-1:0] r_sides;
    logic [COUNT_W-1:0] r_rings;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= 16'd512;
            r_inner <= 16'd256;
            r_sides <= 9'd16;
            r_rings <= 9'd32;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_OUTER: r_outer <= pwdata[RAD_W-1:0];
                REG_INNER: r_inner <= pwdata[RAD_W-1:0];
                REG_SIDES: r_sides <= pwdata[COUNT_W-1:0];
                default:   r_rings <= pwdata[COUNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OUTER: prdata = {16'b0, r_outer};
            REG_INNER: prdata = {16'b0, r_inner};
            REG_SIDES: prdata = {23'b0, r_sides};
            default:   prdata = {23'b0, r_rings};
        endcase
    end

    // request check and quad corner expansion
    logic                r_qbusy;
    logic [CORNER_W-1:0] r_qcnt;
    logic [COUNT_W-1:0]  r_qring;
    logic [SIDE_W-1:0]   r_qside;
    logic                w_acc;
    logic                w_counts_ok;
    logic                w_ok;
    t_sband              r_ent;

    assign busy  = r_qbusy;
    assign w_acc = start && !r_qbusy;
    assign w_counts_ok = (r_sides != '0) && (int'(r_sides) <= MAX_SIDES) &&
                         (r_rings != '0) && (int'(r_rings) <= MAX_RINGS);
    assign w_ok = w_counts_ok && ({1'b0, i_side_index} < r_sides) &&
                  ((i_kind == KIND_QUAD) ? (i_ring_index < r_rings)
                                         : (i_ring_index <= r_rings));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbusy     <= 1'b0;
            r_qcnt      <= '0;
            r_ent.valid <= 1'b0;
        end else if (r_qbusy) begin
            r_ent.valid  <= 1'b1;
            r_ent.kind   <= KIND_QUAD;
            r_ent.bad    <= 1'b0;
            r_ent.corner <= r_qcnt;
            r_ent.ring   <= r_qring;
            r_ent.side   <= r_qside;
            r_qcnt       <= r_qcnt + 1'b1;
            if (int'(r_qcnt) == QUAD_CORNERS - 1) begin
                r_qbusy <= 1'b0;
            end
        end else begin
            r_ent.valid  <= w_acc;
            r_ent.kind   <= i_kind;
            r_ent.bad    <= !w_ok;
            r_ent.corner <= '0;
            r_ent.ring   <= i_ring_index;
            r_ent.side   <= i_side_index;
            r_qring      <= i_ring_index;
            r_qside      <= i_side_index;
            r_qcnt       <= CORNER_W'(1);
            if (w_acc && w_ok && i_kind == KIND_QUAD) begin
                r_qbusy <= 1'b1;
            end
        end
    end

    // trig path
    logic [ANGLE_W-1:0]      w_ang_u;
    logic [ANGLE_W-1:0]      w_ang_v;
    logic signed [NRM_W-1:0] w_cu;
    logic signed [NRM_W-1:0] w_su;
    logic signed [NRM_W-1:0] w_cv;
    logic signed [NRM_W-1:0] w_sv;
    t_radii                  w_radii;

    tmg_angle_div u_div_ring (
        .i_clk   (i_clk),
        .i_idx   (r_ent.ring),
        .i_count (r_rings),
        .o_angle (w_ang_u)
    );

    tmg_angle_div u_div_side (
        .i_clk   (i_clk),
        .i_idx   ({1'b0, r_ent.side}),
        .i_count (r_sides),
        .o_angle (w_ang_v)
    );

    tmg_cordic u_cordic_u (
        .i_clk   (i_clk),
        .i_angle (w_ang_u),
        .o_cos   (w_cu),
        .o_sin   (w_su)
    );

    tmg_cordic u_cordic_v (
        .i_clk   (i_clk),
        .i_angle (w_ang_v),
        .o_cos   (w_cv),
        .o_sin   (w_sv)
    );

    assign w_radii.outer = r_outer;
    assign w_radii.inner = r_inner;

    logic signed [POS_W-1:0] w_px;
    logic signed [POS_W-1:0] w_py;
    logic signed [POS_W-1:0] w_pz;
    logic signed [NRM_W-1:0] w_nx;
    logic signed [NRM_W-1:0] w_ny;
    logic signed [NRM_W-1:0] w_nz;

    tmg_vertex_math u_math (
        .i_clk   (i_clk),
        .i_radii (w_radii),
        .i_cu    (w_cu),
        .i_su    (w_su),
        .i_cv    (w_cv),
        .i_sv    (w_sv),
        .o_px    (w_px),
        .o_py    (w_py),
        .o_pz    (w_pz),
        .o_nx    (w_nx),
        .o_ny    (w_ny),
        .o_nz    (w_nz)
    );

    // sideband line, aligned with the math outputs at its end
    t_sband r_sb [SB_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb[0].valid <= 1'b0;
        end else begin
            r_sb[0] <= r_ent;
        end
    end

    for (genvar k = 1; k < SB_LEN; k++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sb[k].valid <= 1'b0;
            end else begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // quad corner index, one stage ahead of the output
    t_sband             w_qs;
    logic [IDX_W-1:0]   w_base;
    logic [IDX_W-1:0]   w_next;
    logic [SIDE_W:0]    w_nside;
    logic [IDX_W-1:0]   r_qidx;

    assign w_qs    = r_sb[SB_LEN-2];
    assign w_base  = IDX_W'(w_qs.ring * r_sides);
    assign w_next  = w_base + IDX_W'(r_sides);
    assign w_nside = ({1'b0, w_qs.side} + 1'b1 == r_sides) ? '0 : {1'b0, w_qs.side} + 1'b1;

    always_ff @(posedge i_clk) begin
        case (w_qs.corner)
            3'd0, 3'd3: r_qidx <= w_base + IDX_W'(w_qs.side);
            3'd1:       r_qidx <= w_next + IDX_W'(w_qs.side);
            3'd2, 3'd4: r_qidx <= w_next + IDX_W'(w_nside);
            default:    r_qidx <= w_base + IDX_W'(w_nside);
        endcase
    end

    t_sband w_os;
    logic   w_vtx;
    logic   w_quad;

    assign w_os   = r_sb[SB_LEN-1];
    assign w_vtx  = !w_os.bad && w_os.kind == KIND_VERTEX;
    assign w_quad = !w_os.bad && w_os.kind == KIND_QUAD;

    assign o_result_valid = w_os.valid;
    assign o_pos_x        = w_vtx ? w_px : '0;
    assign o_pos_y        = w_vtx ? w_py : '0;
    assign o_pos_z        = w_vtx ? w_pz : '0;
    assign o_normal_x     = w_vtx ? w_nx : '0;
    assign o_normal_y     = w_vtx ? w_ny : '0;
    assign o_normal_z     = w_vtx ? w_nz : '0;
    assign o_vertex_index = w_quad ? r_qidx : '0;
    assign o_bad_request  = w_os.bad;
    assign o_last         = !w_quad || (int'(w_os.corner) == QUAD_CORNERS - 1);

endmodule
